FILE: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY   = 1024;
  localparam int ITEM_WIDTH = 16;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 11;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;

  // internal count and index widths
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int WH_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  // cells per group and number of groups in the chain
  localparam int GROUP_SIZE = 32;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4,
    CMD_REM_POS  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [WH_W-1:0]       where;
    logic [ITEM_WIDTH-1:0] item;
  } pal_op_t;

endpackage

FILE: rtl/pal_if.sv
// ----------------------------------------------------------------------------
// pal_if
// Command and result channels of the positional array list.
// ----------------------------------------------------------------------------
interface pal_in_if import pal_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [POS_W-1:0]      position;
  logic [ITEM_WIDTH-1:0] item;

  modport source (output valid, cmd, position, item, input ready);
  modport sink   (input valid, cmd, position, item, output ready);
endinterface

interface pal_out_if import pal_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ITEM_WIDTH-1:0] removed_item;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    count;

  modport source (output valid, removed_item, status, count, input ready);
  modport sink   (input valid, removed_item, status, count, output ready);
endinterface

FILE: rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: holds, loads the new item, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; (
  input  logic                  clk,
  input  pal_op_t               op,
  input  logic [WH_W-1:0]       idx,
  input  logic [ITEM_WIDTH-1:0] left_in,
  input  logic [ITEM_WIDTH-1:0] right_in,
  output logic [ITEM_WIDTH-1:0] val,
  output logic [ITEM_WIDTH-1:0] tap
);

  logic [ITEM_WIDTH-1:0] val_r;
  logic [ITEM_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (op.ins) begin
      if (idx == op.where) begin
        val_nxt = op.item;
      end else if (idx > op.where) begin
        val_nxt = left_in;
      end
    end else if (op.rem && (idx >= op.where)) begin
      val_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign tap = (op.rem && (idx == op.where)) ? val_r : '0;

endmodule

FILE: rtl/pal_group.sv
// ----------------------------------------------------------------------------
// pal_group
// A run of cells in the shift chain with a registered OR of their taps.
// ----------------------------------------------------------------------------
module pal_group import pal_pkg::*; (
  input  logic                  clk,
  input  pal_op_t               op,
  input  logic [WH_W-1:0]       base,
  input  logic [ITEM_WIDTH-1:0] left_in,
  input  logic [ITEM_WIDTH-1:0] right_in,
  output logic [ITEM_WIDTH-1:0] first_out,
  output logic [ITEM_WIDTH-1:0] last_out,
  output logic [ITEM_WIDTH-1:0] tap_out
);

  logic [ITEM_WIDTH-1:0] vals [GROUP_SIZE];
  logic [ITEM_WIDTH-1:0] taps [GROUP_SIZE];
  logic [ITEM_WIDTH-1:0] tap_or;
  logic [ITEM_WIDTH-1:0] tap_r;

  for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_v;
    logic [ITEM_WIDTH-1:0] right_v;

    if (k == 0) begin : g_lft
      assign left_v = left_in;
    end else begin : g_lft
      assign left_v = vals[k-1];
    end

    if (k == GROUP_SIZE - 1) begin : g_rgt
      assign right_v = right_in;
    end else begin : g_rgt
      assign right_v = vals[k+1];
    end

    pal_cell u_cell (
      .clk      (clk),
      .op       (op),
      .idx      (base + WH_W'(k)),
      .left_in  (left_v),
      .right_in (right_v),
      .val      (vals[k]),
      .tap      (taps[k])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      tap_or = tap_or | taps[k];
    end
  end

  always_ff @(posedge clk) begin
    tap_r <= tap_or;
  end

  assign first_out = vals[0];
  assign last_out  = vals[GROUP_SIZE-1];
  assign tap_out   = tap_r;

endmodule

FILE: rtl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Command decode, checks, entry count and result sequencing.
// ----------------------------------------------------------------------------
module pal_ctrl import pal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pal_in_if.sink                in_ch,
  pal_out_if.source             out_ch,
  input  logic [ITEM_WIDTH-1:0] gathered,
  output pal_op_t               op
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [ITEM_WIDTH-1:0] removed_r;
  logic                  ins_c;
  logic                  rem_c;
  logic [WH_W-1:0]       where_c;
  logic [WH_W-1:0]       cnt_ext;
  logic [WH_W-1:0]       pos_ext;
  logic                  accept;

  assign cnt_ext = WH_W'(count_r);
  assign pos_ext = WH_W'(in_ch.position);
  assign accept  = in_ch.valid && in_ch.ready;

  always_comb begin
    status_nxt = ST_OK;
    ins_c      = 1'b0;
    rem_c      = 1'b0;
    where_c    = '0;
    count_nxt  = count_r;
    unique case (in_ch.cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (in_ch.cmd == CMD_INS_TAIL) begin
          where_c = cnt_ext;
        end else if (in_ch.cmd == CMD_INS_POS) begin
          where_c = pos_ext;
        end
        if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (where_c > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          ins_c     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_POS: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          if (in_ch.cmd == CMD_REM_TAIL) begin
            where_c = cnt_ext - WH_W'(1);
          end else if (in_ch.cmd == CMD_REM_POS) begin
            where_c = pos_ext;
          end
          if (where_c >= cnt_ext) begin
            status_nxt = ST_RANGE;
          end else begin
            rem_c     = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign op.ins   = accept && ins_c;
  assign op.rem   = accept && rem_c;
  assign op.where = where_c;
  assign op.item  = in_ch.item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r  <= count_nxt;
            status_r <= status_nxt;
            state_r  <= S_GATHER;
          end
        end
        S_GATHER: begin
          removed_r <= gathered;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.removed_item = removed_r;
  assign out_ch.status       = status_r;
  assign out_ch.count        = COUNT_W'(count_r);

endmodule

FILE: rtl/positional_array_list.sv
// After a command is accepted, control goes through S_GATHER to S_OUT,
// where the result is valid. A new command is taken only after the result
// is taken. The removed entry leaves the cell chain by a two-level OR gather.
// Every entry shifts in the accept cycle, so the chain length never adds time.
// Reset clears the entry count and the control state; entries are not cleared.
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of item handles held in a shift chain of cells.
// ----------------------------------------------------------------------------
module positional_array_list import pal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_chan,
  pal_out_if.source out_chan
);

  pal_op_t               op;
  logic [ITEM_WIDTH-1:0] firsts [NUM_GROUPS];
  logic [ITEM_WIDTH-1:0] lasts  [NUM_GROUPS];
  logic [ITEM_WIDTH-1:0] gtaps  [NUM_GROUPS];
  logic [ITEM_WIDTH-1:0] gathered;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_chan),
    .out_ch   (out_chan),
    .gathered (gathered),
    .op       (op)
  );

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic [ITEM_WIDTH-1:0] left_v;
    logic [ITEM_WIDTH-1:0] right_v;

    if (g == 0) begin : g_lft
      assign left_v = '0;
    end else begin : g_lft
      assign left_v = lasts[g-1];
    end

    if (g == NUM_GROUPS - 1) begin : g_rgt
      assign right_v = '0;
    end else begin : g_rgt
      assign right_v = firsts[g+1];
    end

    pal_group u_group (
      .clk       (clk),
      .op        (op),
      .base      (WH_W'(g * GROUP_SIZE)),
      .left_in   (left_v),
      .right_in  (right_v),
      .first_out (firsts[g]),
      .last_out  (lasts[g]),
      .tap_out   (gtaps[g])
    );
  end

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gathered = gathered | gtaps[g];
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("new transaction taken before result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  a_fail_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ST_OK)) |-> (out_chan.removed_item == '0))
    else $error("failed command returned an item");

endmodule

FILE: test/pal_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pal_list_checker
// Watches both channels of the positional array list. It keeps a mirror of
// the list, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module pal_list_checker import pal_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pal_in_if    in_mon,
  pal_out_if   out_mon,
  output int   fails,
  output int   awaiting,
  output int   checked,
  output int   n_full,
  output int   n_empty,
  output int   n_range,
  output int   peak_len
);

  typedef struct packed {
    logic [ITEM_WIDTH-1:0] removed;
    status_t               status;
    logic [COUNT_W-1:0]    count;
  } list_result_t;

  logic [ITEM_WIDTH-1:0] mirror [CAPACITY];
  int unsigned           mirror_len;
  list_result_t          pending_results [$];
  list_result_t          want;

  function automatic list_result_t predict_command(input logic [CMD_W-1:0] c,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [ITEM_WIDTH-1:0] it);
    list_result_t r;
    int unsigned  slot;
    r        = '0;
    r.status = ST_OK;
    slot     = 0;
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (c == CMD_INS_TAIL) slot = mirror_len;
        else if (c == CMD_INS_POS) slot = p;
        if (mirror_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (slot > mirror_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = mirror_len; i > slot; i--) mirror[i] = mirror[i-1];
          mirror[slot] = it;
          mirror_len++;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_POS: begin
        if (mirror_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c == CMD_REM_TAIL) slot = mirror_len - 1;
          else if (c == CMD_REM_POS) slot = p;
          if (slot >= mirror_len) begin
            r.status = ST_RANGE;
          end else begin
            r.removed = mirror[slot];
            for (int unsigned i = slot; i + 1 < mirror_len; i++) mirror[i] = mirror[i+1];
            mirror_len--;
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(mirror_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_len = 0;
      fails      = 0;
      checked    = 0;
      n_full     = 0;
      n_empty    = 0;
      n_range    = 0;
      peak_len   = 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t unexpected result: removed_item %h status %0d count %0d",
                   $time, out_mon.removed_item, out_mon.status, out_mon.count);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_mon.removed_item !== want.removed) begin
            fails++;
            $display("%0t removed_item mismatch: expected %h, actual %h",
                     $time, want.removed, out_mon.removed_item);
          end
          if (out_mon.status !== want.status) begin
            fails++;
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_mon.status);
          end
          if (out_mon.count !== want.count) begin
            fails++;
            $display("%0t count mismatch: expected %0d, actual %0d",
                     $time, want.count, out_mon.count);
          end
          case (want.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            ST_RANGE: n_range++;
            default:  ;
          endcase
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(predict_command(in_mon.cmd, in_mon.position,
                                                  in_mon.item));
        if (mirror_len > peak_len) peak_len = mirror_len;
      end
    end
    awaiting = pending_results.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands into the positional array list with random gaps on both
// channels: a directed pass over the corner cases, a random mix, a fill to
// capacity and a drain-biased tail. The checker module judges every result.
// ----------------------------------------------------------------------------
module tb;
  import pal_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int MIX_SEGMENTS = 17;
  localparam int SEGMENT_LEN  = 50;
  localparam int TAIL_ITEMS   = 100;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycles   = 0;
  int unsigned sent     = 0;
  int unsigned list_len = 0;
  int unsigned tx_mode  = 0;
  int unsigned rx_mode  = 0;
  int unsigned rx_taken = 0;

  int fails, awaiting, checked, n_full, n_empty, n_range, peak_len;

  pal_in_if  in_chan();
  pal_out_if out_chan();

  positional_array_list u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pal_list_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_chan),
    .out_mon  (out_chan),
    .fails    (fails),
    .awaiting (awaiting),
    .checked  (checked),
    .n_full   (n_full),
    .n_empty  (n_empty),
    .n_range  (n_range),
    .peak_len (peak_len)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // mode 0: no idling, 1: full range, 2: mostly back to back
  function automatic int unsigned pick_gap(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 12);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  function automatic int unsigned length_after(input logic [CMD_W-1:0] c,
                                               input logic [POS_W-1:0] p,
                                               input int unsigned n);
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL: return (n < CAPACITY) ? n + 1 : n;
      CMD_INS_POS:                return (n < CAPACITY && p <= n) ? n + 1 : n;
      CMD_REM_HEAD, CMD_REM_TAIL: return (n > 0) ? n - 1 : n;
      CMD_REM_POS:                return (n > 0 && p < n) ? n - 1 : n;
      default:                    return n;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int unsigned grow_pct);
    if ($urandom_range(0, 99) < 2) return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    if ($urandom_range(0, 99) < grow_pct)
      return cmd_t'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
    return cmd_t'($urandom_range(CMD_REM_HEAD, CMD_REM_POS));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input logic [CMD_W-1:0] c);
    int unsigned roll;
    int unsigned hi;
    roll = $urandom_range(0, 9);
    hi   = (c == CMD_INS_POS) ? list_len : ((list_len == 0) ? 0 : list_len - 1);
    if (roll == 0) return POS_W'($urandom_range(0, 2047));
    if (roll == 1) return POS_W'(list_len + $urandom_range(0, 1));
    return POS_W'($urandom_range(0, hi));
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                          input logic [ITEM_WIDTH-1:0] it);
    int unsigned gap;
    gap = pick_gap(tx_mode);
    if (gap != 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid    <= 1'b1;
    in_chan.cmd      <= c;
    in_chan.position <= p;
    in_chan.item     <= it;
    do @(posedge clk); while (!in_chan.ready);
    list_len = length_after(c, p, list_len);
    sent++;
  endtask

  initial begin : result_sink
    int unsigned gap;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_taken % 64 == 0) rx_mode = $urandom_range(0, 2);
      gap = (rx_taken == 60 || rx_taken == 1500) ? LONG_HOLD : pick_gap(rx_mode);
      if (gap != 0) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      rx_taken++;
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0] c;
    int unsigned      grow;
    in_chan.valid    = 1'b0;
    in_chan.cmd      = '0;
    in_chan.position = '0;
    in_chan.item     = '0;
    rst_n            = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_REM_HEAD, 11'd0, 16'h1111);
    send_cmd(CMD_REM_TAIL, 11'd0, 16'h2222);
    send_cmd(CMD_REM_POS, 11'd0, 16'h3333);
    send_cmd(CMD_INS_POS, 11'd1, 16'h4444);
    send_cmd(CMD_INS_POS, 11'd0, 16'h0000);
    send_cmd(CMD_INS_HEAD, 11'd7, 16'hFFFF);
    send_cmd(CMD_INS_TAIL, 11'd0, 16'h1234);
    send_cmd(CMD_INS_POS, 11'd3, 16'hA5A5);
    send_cmd(CMD_INS_POS, 11'd1, 16'h5A5A);
    send_cmd(CMD_INS_POS, 11'd2047, 16'hBEEF);
    send_cmd(CMD_INS_POS, 11'd1024, 16'hCAFE);
    send_cmd(CMD_SPARE_6, 11'd2, 16'hFFFF);
    send_cmd(CMD_SPARE_7, 11'd0, 16'h8001);
    send_cmd(CMD_REM_POS, 11'd5, 16'h0000);
    send_cmd(CMD_REM_POS, 11'd2047, 16'h0000);
    send_cmd(CMD_REM_POS, 11'd2, 16'h0000);
    send_cmd(CMD_REM_TAIL, 11'd0, 16'h0000);
    send_cmd(CMD_REM_HEAD, 11'd0, 16'h0000);
    send_cmd(CMD_REM_POS, 11'd0, 16'h0000);
    send_cmd(CMD_REM_HEAD, 11'd0, 16'h0000);
    send_cmd(CMD_REM_TAIL, 11'd0, 16'h0000);

    for (int seg = 0; seg < MIX_SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       grow = 70;
        1:       grow = 30;
        default: grow = 50;
      endcase
      tx_mode = $urandom_range(0, 2);
      repeat (SEGMENT_LEN) begin
        c = pick_cmd(grow);
        send_cmd(c, pick_pos(c), ITEM_WIDTH'($urandom));
      end
    end

    // fill to capacity
    tx_mode = 2;
    while (list_len < CAPACITY) begin
      c = cmd_t'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
      send_cmd(c, POS_W'($urandom_range(0, list_len)), ITEM_WIDTH'($urandom));
    end

    send_cmd(CMD_INS_HEAD, 11'd0, 16'h0F0F);
    send_cmd(CMD_INS_TAIL, 11'd0, 16'hF0F0);
    send_cmd(CMD_INS_POS, 11'd0, 16'h1357);
    send_cmd(CMD_INS_POS, 11'd1024, 16'h2468);
    send_cmd(CMD_INS_POS, 11'd2047, 16'h9999);
    send_cmd(CMD_REM_POS, 11'd1023, 16'h0000);
    send_cmd(CMD_REM_POS, 11'd1023, 16'h0000);
    send_cmd(CMD_INS_POS, 11'd1023, 16'h7E7E);
    send_cmd(CMD_REM_POS, 11'd1024, 16'h0000);
    send_cmd(CMD_REM_TAIL, 11'd0, 16'h0000);
    send_cmd(CMD_INS_POS, 11'd0, 16'hC3C3);

    tx_mode = 1;
    repeat (TAIL_ITEMS) begin
      c = pick_cmd(30);
      send_cmd(c, pick_pos(c), ITEM_WIDTH'($urandom));
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d commands, checked %0d results, peak list length %0d of %0d",
             sent, checked, peak_len, CAPACITY);
    $display("rejected commands: full %0d, empty %0d, out of range %0d",
             n_full, n_empty, n_range);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
